/* sv/i2cmbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master burst sequencer package
// Phase, command and operation codes and the transfer types that the
// sequencer modules share.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

   localparam int COUNT_BITS_DEFAULT = 8;

   localparam logic [1:0] OP_START_WRITE = 2'd0;
   localparam logic [1:0] OP_START_QUERY = 2'd1;
   localparam logic [1:0] OP_INTERRUPT   = 2'd2;

   localparam logic [2:0] CMD_NONE       = 3'd0;
   localparam logic [2:0] CMD_SEND_CONT  = 3'd1;
   localparam logic [2:0] CMD_SEND_FIN   = 3'd2;
   localparam logic [2:0] CMD_RECV_START = 3'd3;
   localparam logic [2:0] CMD_RECV_CONT  = 3'd4;
   localparam logic [2:0] CMD_RECV_FIN   = 3'd5;

   localparam logic [2:0] PHASE_CODE_IDLE      = 3'd0;
   localparam logic [2:0] PHASE_CODE_WRITE     = 3'd1;
   localparam logic [2:0] PHASE_CODE_WRITE_FIN = 3'd2;
   localparam logic [2:0] PHASE_CODE_QUERY     = 3'd3;
   localparam logic [2:0] PHASE_CODE_QUERY_FIN = 3'd4;
   localparam logic [2:0] PHASE_CODE_READ      = 3'd5;
   localparam logic [2:0] PHASE_CODE_READ_FIN  = 3'd6;

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_WRITE     = 7'b0000010,
      PH_WRITE_FIN = 7'b0000100,
      PH_QUERY     = 7'b0001000,
      PH_QUERY_FIN = 7'b0010000,
      PH_READ      = 7'b0100000,
      PH_READ_FIN  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] write_len;
      logic [7:0] read_len;
      logic [7:0] write_byte;
      logic [7:0] read_byte;
   } item_type;

   typedef struct packed {
      logic       put_valid;
      logic [7:0] put_byte;
      logic [2:0] command;
      logic       addr_load;
      logic [6:0] target_address;
      logic       store_valid;
      logic [7:0] store_byte;
      logic [7:0] store_index;
      logic [7:0] next_write_index;
      logic [2:0] phase;
   } result_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_IDLE:      code = PHASE_CODE_IDLE;
         PH_WRITE:     code = PHASE_CODE_WRITE;
         PH_WRITE_FIN: code = PHASE_CODE_WRITE_FIN;
         PH_QUERY:     code = PHASE_CODE_QUERY;
         PH_QUERY_FIN: code = PHASE_CODE_QUERY_FIN;
         PH_READ:      code = PHASE_CODE_READ;
         PH_READ_FIN:  code = PHASE_CODE_READ_FIN;
         default:      code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* sv/i2cmbs_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master burst sequencer state
// Holds the phase and the byte counters and works out the result of one
// transfer from the registered input item.
// ----------------------------------------------------------------------------
module i2cmbs_seq #(
   parameter int COUNT_BITS = i2cmbs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  i2cmbs_pkg::item_type   item,
   input  logic [6:0]             slave_address,
   output i2cmbs_pkg::result_type result
);

   localparam int EXT_BITS = COUNT_BITS + 8;
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   i2cmbs_pkg::phase_type phase_ff, phase_in;
   logic [COUNT_BITS-1:0] write_left_ff, write_left_in;
   logic [COUNT_BITS-1:0] read_left_ff, read_left_in;
   logic [COUNT_BITS-1:0] write_pos_ff, write_pos_in;
   logic [COUNT_BITS-1:0] read_pos_ff, read_pos_in;

   logic [EXT_BITS-1:0]   write_len_ext, read_len_ext;
   logic [EXT_BITS-1:0]   write_pos_ext, read_pos_ext;
   logic [COUNT_BITS-1:0] write_len_cnt, read_len_cnt;
   logic [COUNT_BITS-1:0] write_left_dec, read_left_dec;

   assign write_len_ext  = {{COUNT_BITS{1'b0}}, item.write_len};
   assign read_len_ext   = {{COUNT_BITS{1'b0}}, item.read_len};
   assign write_len_cnt  = write_len_ext[COUNT_BITS-1:0];
   assign read_len_cnt   = read_len_ext[COUNT_BITS-1:0];
   assign write_left_dec = (write_left_ff == '0) ? '0 : write_left_ff - CNT_ONE;
   assign read_left_dec  = (read_left_ff == '0) ? '0 : read_left_ff - CNT_ONE;
   assign write_pos_ext  = {8'd0, write_pos_in};
   assign read_pos_ext   = {8'd0, read_pos_ff};

   always_comb begin
      phase_in      = phase_ff;
      write_left_in = write_left_ff;
      read_left_in  = read_left_ff;
      write_pos_in  = write_pos_ff;
      read_pos_in   = read_pos_ff;
      result        = '0;
      result.command = i2cmbs_pkg::CMD_NONE;

      case (item.op)
         i2cmbs_pkg::OP_START_WRITE, i2cmbs_pkg::OP_START_QUERY: begin
            write_left_in = write_len_cnt;
            read_left_in  = read_len_cnt;
            write_pos_in  = '0;
            read_pos_in   = '0;
            if (item.op == i2cmbs_pkg::OP_START_WRITE) begin
               phase_in = (write_len_cnt <= CNT_ONE) ? i2cmbs_pkg::PH_WRITE_FIN
                                                     : i2cmbs_pkg::PH_WRITE;
            end else begin
               phase_in = (write_len_cnt <= CNT_ONE) ? i2cmbs_pkg::PH_QUERY_FIN
                                                     : i2cmbs_pkg::PH_QUERY;
            end
         end
         i2cmbs_pkg::OP_INTERRUPT: begin
            case (phase_ff)
               i2cmbs_pkg::PH_WRITE, i2cmbs_pkg::PH_QUERY: begin
                  result.put_valid = 1'b1;
                  result.put_byte  = item.write_byte;
                  result.command   = i2cmbs_pkg::CMD_SEND_CONT;
                  write_left_in    = write_left_dec;
                  write_pos_in     = write_pos_ff + CNT_ONE;
                  if (write_left_dec <= CNT_ONE) begin
                     phase_in = (phase_ff == i2cmbs_pkg::PH_WRITE)
                                ? i2cmbs_pkg::PH_WRITE_FIN : i2cmbs_pkg::PH_QUERY_FIN;
                  end
               end
               i2cmbs_pkg::PH_WRITE_FIN: begin
                  result.put_valid = 1'b1;
                  result.put_byte  = item.write_byte;
                  result.command   = i2cmbs_pkg::CMD_SEND_FIN;
                  phase_in         = i2cmbs_pkg::PH_IDLE;
               end
               i2cmbs_pkg::PH_QUERY_FIN: begin
                  result.put_valid      = 1'b1;
                  result.put_byte       = item.write_byte;
                  result.command        = i2cmbs_pkg::CMD_RECV_START;
                  result.addr_load      = 1'b1;
                  result.target_address = slave_address;
                  phase_in = (read_left_ff <= CNT_ONE) ? i2cmbs_pkg::PH_READ_FIN
                                                       : i2cmbs_pkg::PH_READ;
               end
               i2cmbs_pkg::PH_READ: begin
                  result.store_valid = 1'b1;
                  result.store_byte  = item.read_byte;
                  result.store_index = read_pos_ext[7:0];
                  result.command     = i2cmbs_pkg::CMD_RECV_CONT;
                  read_pos_in        = read_pos_ff + CNT_ONE;
                  read_left_in       = read_left_dec;
                  if (read_left_dec <= CNT_ONE) begin
                     phase_in = i2cmbs_pkg::PH_READ_FIN;
                  end
               end
               i2cmbs_pkg::PH_READ_FIN: begin
                  result.store_valid = 1'b1;
                  result.store_byte  = item.read_byte;
                  result.store_index = read_pos_ext[7:0];
                  result.command     = i2cmbs_pkg::CMD_RECV_FIN;
                  phase_in           = i2cmbs_pkg::PH_IDLE;
               end
               default: begin
                  phase_in = i2cmbs_pkg::PH_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase

      result.next_write_index = write_pos_ext[7:0];
      result.phase            = i2cmbs_pkg::phase_code(phase_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cmbs_pkg::PH_IDLE;
         write_left_ff <= '0;
         read_left_ff  <= '0;
         write_pos_ff  <= '0;
         read_pos_ff   <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         write_left_ff <= write_left_in;
         read_left_ff  <= read_left_in;
         write_pos_ff  <= write_pos_in;
         read_pos_ff   <= read_pos_in;
      end
   end

   // On an interrupt, the read counters only move in the read phase.
   a_read_pos_hold: assert property (@(posedge clock) disable iff (reset)
      (step_en && item.op == i2cmbs_pkg::OP_INTERRUPT && phase_ff != i2cmbs_pkg::PH_READ)
      |=> $stable(read_pos_ff))
      else $error("read position moved outside the read phase");

   a_final_write_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == i2cmbs_pkg::PH_WRITE || phase_ff == i2cmbs_pkg::PH_QUERY)
      |-> write_left_ff > CNT_ONE)
      else $error("write phase with one byte or less left");

   a_query_switch: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.addr_load) |=> (phase_ff == i2cmbs_pkg::PH_READ
                                      || phase_ff == i2cmbs_pkg::PH_READ_FIN))
      else $error("address load did not enter a read phase");

endmodule

/* sv/i2c_master_burst_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master burst sequencer
// Steps an I2C master through a burst write or a write followed by a read.
//
// A transfer on the req channel is either a start (write or write-then-read
// query, taking the byte counts) or a controller interrupt carrying the byte
// to send and the byte received. Each request yields exactly one transfer on
// the rsp channel with the command to issue, the byte to put, the received
// byte to store with its index, and the next write index and phase.
// The slave address for the receive phase is written through csr_wr_en and
// csr_wr_data; the user keeps this to while the block is idle, unenforced.
// A request is captured in an input register, evaluated against the phase
// and counters, and lands in the result register; while rsp_stall is low,
// one request per cycle is sustained. When rsp_stall holds a result,
// the input register keeps the next request and req_stall rises only once
// that register is also full. Reset returns the sequencer to idle, clears
// the counters and the slave address, and empties both registers.
// ----------------------------------------------------------------------------
module i2c_master_burst_sequencer_core #(
   parameter int COUNT_BITS = i2cmbs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_write_len,
   input  logic [7:0] req_read_len,
   input  logic [7:0] req_write_byte,
   input  logic [7:0] req_read_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_put_valid,
   output logic [7:0] rsp_put_byte,
   output logic [2:0] rsp_command,
   output logic       rsp_addr_load,
   output logic [6:0] rsp_target_address,
   output logic       rsp_store_valid,
   output logic [7:0] rsp_store_byte,
   output logic [7:0] rsp_store_index,
   output logic [7:0] rsp_next_write_index,
   output logic [2:0] rsp_phase
);

   logic                   slave_address_ff;
   logic [6:0]             slave_addr_ff;
   logic                   in_valid_ff, in_valid_in;
   i2cmbs_pkg::item_type   item_ff;
   logic                   out_valid_ff, out_valid_in;
   i2cmbs_pkg::result_type result_ff;
   i2cmbs_pkg::result_type result;
   logic                   advance;
   logic                   req_take;

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   i2cmbs_seq #(
      .COUNT_BITS(COUNT_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .item         (item_ff),
      .slave_address(slave_addr_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff    <= '0;
         slave_address_ff <= 1'b0;
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slave_addr_ff    <= csr_wr_data;
            slave_address_ff <= 1'b1;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.op         <= req_op;
         item_ff.write_len  <= req_write_len;
         item_ff.read_len   <= req_read_len;
         item_ff.write_byte <= req_write_byte;
         item_ff.read_byte  <= req_read_byte;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_put_valid        = result_ff.put_valid;
   assign rsp_put_byte         = result_ff.put_byte;
   assign rsp_command          = result_ff.command;
   assign rsp_addr_load        = result_ff.addr_load;
   assign rsp_target_address   = result_ff.target_address;
   assign rsp_store_valid      = result_ff.store_valid;
   assign rsp_store_byte       = result_ff.store_byte;
   assign rsp_store_index      = result_ff.store_index;
   assign rsp_next_write_index = result_ff.next_write_index;
   assign rsp_phase            = result_ff.phase;

   a_addr_load_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_addr_load) |-> rsp_command == i2cmbs_pkg::CMD_RECV_START)
      else $error("address load without receive start");

   a_store_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_valid) |-> (rsp_command == i2cmbs_pkg::CMD_RECV_CONT
                                       || rsp_command == i2cmbs_pkg::CMD_RECV_FIN))
      else $error("store without a receive command");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(result_ff)))
      else $error("stalled result changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_addr_load && !slave_address_ff) |-> rsp_target_address == 7'd0)
      else $error("target address without a written slave address");

endmodule
